[rtl/servo_status_packet_parser_unit_macros.svh]
`ifndef SERVO_STATUS_PACKET_PARSER_UNIT_MACROS_SVH
`define SERVO_STATUS_PACKET_PARSER_UNIT_MACROS_SVH

// Assertions sampled on clk, switched off while rst_n is low.
// Same-cycle implication.
`define SSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ssp_pkg.sv]
package ssp_pkg;

    localparam int KEPT_PARAMS = 8;
    localparam int IDX_W       = $clog2(KEPT_PARAMS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] START_BYTE        = 8'hFF;
    localparam logic [7:0] EXPECTED_ID_RESET = 8'h01;
    localparam logic [7:0] MIN_LENGTH        = 8'd2;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_CSUM_BAD    = 2'd1,
        STATUS_ID_MISMATCH = 2'd2,
        STATUS_SHORT_LEN   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_PARAM  = 2'd1,
        CMD_REPORT = 2'd2
    } cmd_op_t;

    // One unit of work from the parser to the executing side.
    typedef struct packed {
        cmd_op_t          op;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
        status_t          status;
    } cmd_t;

    // Occupancy of the command queue.
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } qstat_t;

endpackage

[rtl/ssp_interfaces.sv]
interface ssp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ssp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] expected_id;

    modport source (output valid, output expected_id, input ready);
    modport sink (input valid, input expected_id, output ready);
endinterface

interface ssp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  servo_error_flags;
    logic [15:0] position;
    logic [15:0] speed;
    logic [8:0]  load;
    logic [7:0]  voltage;
    logic [7:0]  temperature;

    modport source (
        output valid, output status, output servo_error_flags, output position,
        output speed, output load, output voltage, output temperature,
        input ready
    );
    modport sink (
        input valid, input status, input servo_error_flags, input position,
        input speed, input load, input voltage, input temperature,
        output ready
    );
endinterface

[rtl/ssp_front.sv]
module ssp_front (
    input  logic             clk,
    input  logic             rst_n,
    ssp_rx_if.sink           rx,
    ssp_cfg_if.sink          cfg,
    input  ssp_pkg::qstat_t  qstat,
    output logic             push,
    output ssp_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_ID    = 3'd2,
        PH_LEN   = 3'd3,
        PH_ERR   = 3'd4,
        PH_PARAM = 3'd5,
        PH_CSUM  = 3'd6
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] id_reg;
    logic [7:0] length_reg, length_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] err_reg, err_next;
    logic [7:0] count_plus;
    logic [7:0] sum_plus;
    logic       accept;
    logic [7:0] b;

    assign cfg.ready  = 1'b1;
    // Every byte may produce a command, so a byte is only taken when the queue has room.
    assign rx.ready   = !qstat.full;
    assign accept     = rx.valid && rx.ready;
    assign b          = rx.rx_byte;
    assign count_plus = count_reg + 8'd1;
    assign sum_plus   = sum_reg + b;

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        err_next    = err_reg;
        push        = 1'b0;
        cmd.op      = ssp_pkg::CMD_CLEAR;
        cmd.idx     = count_reg[ssp_pkg::IDX_W-1:0];
        cmd.data    = b;
        cmd.status  = ssp_pkg::STATUS_OK;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT1:
                begin
                    if (b == ssp_pkg::START_BYTE)
                        phase_next = PH_HUNT2;
                end
                PH_HUNT2:
                begin
                    phase_next = (b == ssp_pkg::START_BYTE) ? PH_ID : PH_HUNT1;
                end
                PH_ID:
                begin
                    if (b != id_reg)
                    begin
                        phase_next = PH_HUNT1;
                        push       = 1'b1;
                        cmd.op     = ssp_pkg::CMD_REPORT;
                        cmd.data   = 8'd0;
                        cmd.status = ssp_pkg::STATUS_ID_MISMATCH;
                    end
                    else
                    begin
                        sum_next   = b;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    push = 1'b1;
                    if (b < ssp_pkg::MIN_LENGTH)
                    begin
                        phase_next = PH_HUNT1;
                        cmd.op     = ssp_pkg::CMD_REPORT;
                        cmd.data   = 8'd0;
                        cmd.status = ssp_pkg::STATUS_SHORT_LEN;
                    end
                    else
                    begin
                        length_next = b;
                        count_next  = 8'd0;
                        sum_next    = sum_plus;
                        phase_next  = PH_ERR;
                        cmd.op      = ssp_pkg::CMD_CLEAR;
                    end
                end
                PH_ERR:
                begin
                    err_next   = b;
                    sum_next   = sum_plus;
                    phase_next = (length_reg == ssp_pkg::MIN_LENGTH) ? PH_CSUM : PH_PARAM;
                end
                PH_PARAM:
                begin
                    // Every parameter enters the sum; only the leading ones are stored.
                    if (count_reg < 8'(ssp_pkg::KEPT_PARAMS))
                    begin
                        push   = 1'b1;
                        cmd.op = ssp_pkg::CMD_PARAM;
                    end
                    sum_next   = sum_plus;
                    count_next = count_plus;
                    if (count_plus >= (length_reg - ssp_pkg::MIN_LENGTH))
                        phase_next = PH_CSUM;
                end
                PH_CSUM:
                begin
                    phase_next = PH_HUNT1;
                    push       = 1'b1;
                    cmd.op     = ssp_pkg::CMD_REPORT;
                    cmd.data   = err_reg;
                    cmd.status = (~sum_reg == b) ? ssp_pkg::STATUS_OK
                                                 : ssp_pkg::STATUS_CSUM_BAD;
                end
                default:
                begin
                    phase_next = PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT1;
            id_reg     <= ssp_pkg::EXPECTED_ID_RESET;
            length_reg <= 8'd0;
            count_reg  <= 8'd0;
            sum_reg    <= 8'd0;
            err_reg    <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            err_reg    <= err_next;
            if (cfg.valid && cfg.ready)
                id_reg <= cfg.expected_id;
        end
    end

endmodule

[rtl/ssp_queue.sv]
module ssp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ssp_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output ssp_pkg::cmd_t    head_cmd,
    output ssp_pkg::qstat_t  qstat
);

    ssp_pkg::cmd_t                entry_reg [ssp_pkg::QUEUE_DEPTH];
    logic [ssp_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ssp_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ssp_pkg::QCNT_W-1:0]   count_reg, count_next;

    localparam logic [ssp_pkg::QPTR_W-1:0] LAST_PTR = ssp_pkg::QPTR_W'(ssp_pkg::QUEUE_DEPTH - 1);

    assign head_cmd    = entry_reg[rd_ptr_reg];
    assign qstat.count = count_reg;
    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == ssp_pkg::QCNT_W'(ssp_pkg::QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[rtl/ssp_back.sv]
module ssp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  ssp_pkg::qstat_t  qstat,
    input  ssp_pkg::cmd_t    head_cmd,
    output logic             pop,
    ssp_result_if.source     result
);

    logic [7:0]  store_reg [ssp_pkg::KEPT_PARAMS];
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [7:0]  flags_reg;
    logic [15:0] position_reg;
    logic [15:0] speed_reg;
    logic [8:0]  load_reg;
    logic [7:0]  voltage_reg;
    logic [7:0]  temperature_reg;

    // The held values only change when a new report enters the output slot,
    // so they serve directly as the result payload.
    assign result.valid             = out_valid_reg;
    assign result.status            = status_reg;
    assign result.servo_error_flags = flags_reg;
    assign result.position          = position_reg;
    assign result.speed             = speed_reg;
    assign result.load              = load_reg;
    assign result.voltage           = voltage_reg;
    assign result.temperature       = temperature_reg;

    assign pop = !qstat.empty && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            position_reg    <= 16'd0;
            speed_reg       <= 16'd0;
            load_reg        <= 9'd0;
            voltage_reg     <= 8'd0;
            temperature_reg <= 8'd0;
            for (int i = 0; i < ssp_pkg::KEPT_PARAMS; i++)
                store_reg[i] <= 8'd0;
        end
        else
        begin
            if (result.ready)
                out_valid_reg <= 1'b0;
            if (pop)
            begin
                unique case (head_cmd.op)
                    ssp_pkg::CMD_CLEAR:
                    begin
                        for (int i = 0; i < ssp_pkg::KEPT_PARAMS; i++)
                            store_reg[i] <= 8'd0;
                    end
                    ssp_pkg::CMD_PARAM:
                    begin
                        store_reg[head_cmd.idx] <= head_cmd.data;
                    end
                    ssp_pkg::CMD_REPORT:
                    begin
                        out_valid_reg <= 1'b1;
                        if (head_cmd.status == ssp_pkg::STATUS_OK)
                        begin
                            position_reg    <= {store_reg[1], store_reg[0]};
                            speed_reg       <= {store_reg[3], store_reg[2]};
                            load_reg        <= {store_reg[5][0], store_reg[4]};
                            voltage_reg     <= store_reg[6];
                            temperature_reg <= store_reg[7];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_cmd.op == ssp_pkg::CMD_REPORT)
        begin
            status_reg <= head_cmd.status;
            flags_reg  <= head_cmd.data;
        end
    end

endmodule

[rtl/servo_status_packet_parser_unit.sv]
// Servo status packet parser. Bytes from the servo line enter on rx, one per
// transfer, and one byte can be taken in every clock cycle while the queue
// has room. The front end hunts for the two 0xFF start bytes, checks the ID
// against expected_id (written on cfg, reset value 1), the length byte and
// the inverted-sum checksum, and passes store, clear and report commands
// through a four-entry queue to the back end, which holds the first eight
// parameters and the decoded position, speed, load, voltage and temperature.
// A result transfer is made for every checksum byte and for every rejected
// ID or length byte; it is registered in the queue and then in the output
// slot. A stalled result stops the back end only; the front keeps taking
// bytes until the queue is full. Write cfg only while the block is idle.
`include "servo_status_packet_parser_unit_macros.svh"

module servo_status_packet_parser_unit (
    input  logic          clk,
    input  logic          rst_n,
    ssp_rx_if.sink        rx,
    ssp_cfg_if.sink       cfg,
    ssp_result_if.source  result
);

    logic             push;
    logic             pop;
    ssp_pkg::cmd_t    push_cmd;
    ssp_pkg::cmd_t    head_cmd;
    ssp_pkg::qstat_t  qstat;

    ssp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .cfg   (cfg),
        .qstat (qstat),
        .push  (push),
        .cmd   (push_cmd)
    );

    ssp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .qstat    (qstat)
    );

    ssp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .head_cmd (head_cmd),
        .pop      (pop),
        .result   (result)
    );

    `SSP_ASSERT_NOW(a_push_has_room, push, !qstat.full, "command pushed into a full queue")
    `SSP_ASSERT_NOW(a_pop_not_empty, pop, !qstat.empty, "command popped from an empty queue")
    `SSP_ASSERT_NEXT(a_report_fills_slot, pop && head_cmd.op == ssp_pkg::CMD_REPORT, result.valid, "report did not reach the output")
    `SSP_ASSERT_NEXT(a_idle_queue_keeps, qstat.empty && !push, qstat.empty, "queue filled without a push")

endmodule
